// File: design/tbphd_pkg.sv
// ----------------------------------------------------------------------------
// tbphd_pkg
// Shared types and constants of the two-button press/hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tbphd_pkg;

    localparam int THRESH_W = 16;

    localparam logic [THRESH_W-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [THRESH_W-1:0] HOLD_RESET     = 16'd3000;

    // configuration register indexes
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_HOLD     = 1'b1;

    typedef struct packed {
        logic left_main_n;
        logic left_extra_n;
        logic right_main_n;
        logic right_extra_n;
    } pins_t;

    typedef struct packed {
        logic left_press;
        logic right_press;
        logic left_hold;
        logic right_hold;
    } result_t;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce_ticks;
        logic [THRESH_W-1:0] hold_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/tbphd_if.sv
// ----------------------------------------------------------------------------
// tbphd_if
// Valid/ready channels for pin samples and for detector reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbphd_sample_if;
    logic valid;
    logic ready;
    logic left_main_n;
    logic left_extra_n;
    logic right_main_n;
    logic right_extra_n;

    modport source (output valid, output left_main_n, output left_extra_n,
                    output right_main_n, output right_extra_n, input ready);
    modport sink   (input valid, input left_main_n, input left_extra_n,
                    input right_main_n, input right_extra_n, output ready);
endinterface

interface tbphd_report_if;
    logic valid;
    logic ready;
    logic left_press;
    logic right_press;
    logic left_hold;
    logic right_hold;

    modport source (output valid, output left_press, output right_press,
                    output left_hold, output right_hold, input ready);
    modport sink   (input valid, input left_press, input right_press,
                    input left_hold, input right_hold, output ready);
endinterface

`default_nettype wire

// File: design/two_button_press_hold_detector_core.sv
// ----------------------------------------------------------------------------
// two_button_press_hold_detector_core
// Debounced short-press and long-hold detection for two buttons of two pins.
// ----------------------------------------------------------------------------
// Each request on sample is one time tick with four active-low pin levels.
// A side is pressed while either of its pins is low. After the debounce
// interval the enabled pressed sides are latched; a report on report carries
// the short presses once the sides are released, or the holds once a side has
// stayed down for hold_ticks ticks. Ticks that decide nothing give no report.
// A report passes the input register, then the result register. Throughput:
// one tick per cycle while report is not stalled, as the engine updates its
// state on every accepted tick.
// A stalled report holds its slot; sample keeps accepting until the input
// register is also full, then ready drops until report is taken.
// Reset empties both registers, enables both sides and loads the debounce
// and hold intervals with 100 and 3000 ticks. The write port sets them at any
// time; they are meant to change only while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_press_hold_detector_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    tbphd_sample_if.sink                 sample,
    tbphd_report_if.source               report,
    input  wire                          wr_en,
    input  wire                          wr_index,
    input  wire [tbphd_pkg::THRESH_W-1:0] wr_data
);
    import tbphd_pkg::*;

    logic    in_valid_reg;
    pins_t   in_pins_reg;
    cfg_t    cfg_reg;
    logic    take;
    logic    res_valid;
    result_t res;

    assign sample.ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.valid && sample.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_pins_reg <= '{left_main_n:   sample.left_main_n,
                             left_extra_n:  sample.left_extra_n,
                             right_main_n:  sample.right_main_n,
                             right_extra_n: sample.right_extra_n};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{debounce_ticks: DEBOUNCE_RESET, hold_ticks: HOLD_RESET};
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= wr_data;
                REG_HOLD:     cfg_reg.hold_ticks     <= wr_data;
                default:      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    tbphd_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_pins  (in_pins_reg),
        .item_take  (take),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (report.ready)
    );

    assign report.valid       = res_valid;
    assign report.left_press  = res.left_press;
    assign report.right_press = res.right_press;
    assign report.left_hold   = res.left_hold;
    assign report.right_hold  = res.right_hold;

endmodule

`default_nettype wire

// File: design/tbphd_engine.sv
// ----------------------------------------------------------------------------
// tbphd_engine
// Press/hold state machine with its result register, one request per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tbphd_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    input  tbphd_pkg::pins_t    item_pins,
    output logic                item_take,
    input  tbphd_pkg::cfg_t     cfg,
    output logic                res_valid,
    output tbphd_pkg::result_t  res,
    input  wire                 res_ready
);
    import tbphd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_HOLD
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic [1:0]             allowed_reg, allowed_next;
    logic [1:0]             latched_reg, latched_next;
    logic                   res_valid_reg;
    result_t                res_reg, res_next;

    logic [1:0]             pressed;
    logic [1:0]             latch_now;
    logic [CMP_W-1:0]       count_ext, debounce_ext, hold_ext;

    assign pressed      = {~(item_pins.right_main_n & item_pins.right_extra_n),
                           ~(item_pins.left_main_n & item_pins.left_extra_n)};
    assign count_inc    = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                             : count_reg + 1'b1;
    assign count_ext    = CMP_W'(count_inc);
    assign debounce_ext = CMP_W'(cfg.debounce_ticks);
    assign hold_ext     = CMP_W'(cfg.hold_ticks);
    assign latch_now    = pressed & allowed_reg;

    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        allowed_next = allowed_reg;
        latched_next = latched_reg;
        res_next     = '0;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                count_next = count_inc;
                if (count_ext >= debounce_ext)
                begin
                    latched_next = latch_now;
                    phase_next   = PH_IDLE;
                    count_next   = '0;
                    if (latch_now != 2'b00)
                    begin
                        if (cfg.hold_ticks == '0)
                        begin
                            // hold fires on the sampling tick
                            res_next     = '{left_press:  latch_now[0] & ~pressed[0],
                                             right_press: latch_now[1] & ~pressed[1],
                                             left_hold:   pressed[0],
                                             right_hold:  pressed[1]};
                            allowed_next = allowed_reg & ~pressed;
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                        end
                    end
                end
            end
            PH_HOLD:
            begin
                if (latch_now == 2'b00)
                begin
                    res_next   = '{left_press:  latched_reg[0],
                                   right_press: latched_reg[1],
                                   left_hold:   1'b0,
                                   right_hold:  1'b0};
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                    if (count_ext >= hold_ext)
                    begin
                        res_next     = '{left_press:  latched_reg[0] & ~pressed[0],
                                         right_press: latched_reg[1] & ~pressed[1],
                                         left_hold:   pressed[0],
                                         right_hold:  pressed[1]};
                        allowed_next = allowed_reg & ~pressed;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                allowed_next = allowed_reg | ~pressed;
                if (pressed != 2'b00)
                begin
                    phase_next = PH_DEBOUNCE;
                    count_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            allowed_reg   <= 2'b11;
            latched_reg   <= 2'b00;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (item_take)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            allowed_reg   <= allowed_next;
            latched_reg   <= latched_next;
            res_valid_reg <= (res_next != '0);
            res_reg       <= res_next;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: design/tbphd_checker.sv
// ----------------------------------------------------------------------------
// tbphd_checker
// Port-level checks of the press/hold detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tbphd_checker (
    input wire clk,
    input wire rst_n,
    input wire sample_ready,
    input wire report_valid,
    input wire report_ready,
    input wire left_press,
    input wire right_press,
    input wire left_hold,
    input wire right_hold
);

    // a report always carries at least one event
    a_report_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (left_press || right_press || left_hold || right_hold))
        else $error("empty report");

    // a side is never reported as press and hold together
    a_press_or_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> !(left_press && left_hold) && !(right_press && right_hold))
        else $error("press and hold on one side");

    // with the report slot empty the block never refuses a tick
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !report_valid |-> sample_ready)
        else $error("sample stalled without back pressure");

    // a stalled report holds
    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid
            && $stable(left_press) && $stable(right_press)
            && $stable(left_hold) && $stable(right_hold))
        else $error("stalled report changed");

endmodule

bind two_button_press_hold_detector_core tbphd_checker u_tbphd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .left_press   (report.left_press),
    .right_press  (report.right_press),
    .left_hold    (report.left_hold),
    .right_hold   (report.right_hold)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-button press/hold detector core.
// ----------------------------------------------------------------------------
// Pin samples are offered in bursts with random gaps, and reports are taken
// under a changing stall pattern. Each accepted sample is run through an
// in-bench model of the debounce, latch, hold and re-enable behaviour. Each
// report is then compared field by field with the oldest expected one. The
// run starts at the reset intervals. It then steps through short directed
// sequences and random phases of gestures and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbphd_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int REPORT_LATENCY = 2;
    localparam int LONG_STALL     = 400;
    localparam logic [3:0] RELEASED = 4'b1111;

    typedef enum logic [1:0] {
        DET_IDLE     = 2'd0,
        DET_DEBOUNCE = 2'd1,
        DET_HOLD     = 2'd2
    } det_stage_e;

    class report_scoreboard;
        det_stage_e          stage;
        logic [THRESH_W-1:0] tick_cnt;
        logic [THRESH_W-1:0] debounce_ticks;
        logic [THRESH_W-1:0] hold_ticks;
        logic                left_on;
        logic                right_on;
        logic [1:0]          latched_sides;
        result_t             expected_reports [$];
        int                  failures;

        function new();
            stage          = DET_IDLE;
            tick_cnt       = '0;
            debounce_ticks = DEBOUNCE_RESET;
            hold_ticks     = HOLD_RESET;
            left_on        = 1'b1;
            right_on       = 1'b1;
            latched_sides  = 2'b00;
            failures       = 0;
        endfunction

        function void configure(logic [THRESH_W-1:0] deb, logic [THRESH_W-1:0] hold);
            debounce_ticks = deb;
            hold_ticks     = hold;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void bump();
            if (tick_cnt != '1)
                tick_cnt++;
        endfunction

        // bit 0 left, bit 1 right; returns {holds, presses}
        function logic [3:0] fire_hold(logic [1:0] down);
            logic [1:0] presses;
            presses = latched_sides & ~down;
            if (down[0])
                left_on = 1'b0;
            if (down[1])
                right_on = 1'b0;
            stage    = DET_IDLE;
            tick_cnt = '0;
            return {down, presses};
        endfunction

        function void note_tick(pins_t p);
            logic [1:0] down;
            logic [1:0] enabled;
            logic [3:0] code;
            down[0] = ~(p.left_main_n & p.left_extra_n);
            down[1] = ~(p.right_main_n & p.right_extra_n);
            enabled = {right_on, left_on};
            code    = 4'b0000;
            case (stage)
                DET_DEBOUNCE:
                begin
                    bump();
                    if (tick_cnt >= debounce_ticks)
                    begin
                        latched_sides = down & enabled;
                        if (latched_sides == 2'b00)
                        begin
                            stage    = DET_IDLE;
                            tick_cnt = '0;
                        end
                        else if (hold_ticks == '0)
                            code = fire_hold(down);
                        else
                        begin
                            stage    = DET_HOLD;
                            tick_cnt = '0;
                        end
                    end
                end
                DET_HOLD:
                begin
                    if ((down & enabled) == 2'b00)
                    begin
                        code     = {2'b00, latched_sides};
                        stage    = DET_IDLE;
                        tick_cnt = '0;
                    end
                    else
                    begin
                        bump();
                        if (tick_cnt >= hold_ticks)
                            code = fire_hold(down);
                    end
                end
                default:
                begin
                    stage = DET_IDLE;
                    if (!down[0])
                        left_on = 1'b1;
                    if (!down[1])
                        right_on = 1'b1;
                    if (down != 2'b00)
                    begin
                        stage    = DET_DEBOUNCE;
                        tick_cnt = '0;
                    end
                end
            endcase
            if (code != 4'b0000)
                expected_reports.push_back(result_t'{left_press: code[0],
                    right_press: code[1], left_hold: code[2], right_hold: code[3]});
        endfunction

        function void check_report(result_t got);
            result_t want;
            string   field [4];
            field = '{"left_press", "right_press", "left_hold", "right_hold"};
            if (expected_reports.size() == 0)
            begin
                $error("report %b with none expected", got);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            for (int i = 0; i < 4; i++)
            begin
                if (got[3-i] !== want[3-i])
                begin
                    $error("%s: expected %0b, actual %0b", field[i], want[3-i], got[3-i]);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                wr_en;
    logic                wr_index;
    logic [THRESH_W-1:0] wr_data;

    tbphd_sample_if sample_ch ();
    tbphd_report_if report_ch ();

    report_scoreboard sb = new();

    int                  ticks_sent;
    int                  burst_left;
    int                  stall_asks;
    int                  stall_seen;
    int                  stall_left;
    int                  rx_mode;
    int                  rx_count;
    logic [31:0]         rx_pattern;
    logic [THRESH_W-1:0] cur_deb;
    logic [THRESH_W-1:0] cur_hold;

    two_button_press_hold_detector_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .report   (report_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: checks reports and stalls on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
            stall_seen = 0;
            stall_left = 0;
            rx_mode    = 0;
            rx_count   = 0;
            rx_pattern = '0;
        end
        else
        begin
            if (report_ch.valid && report_ch.ready)
                sb.check_report(result_t'{report_ch.left_press, report_ch.right_press,
                    report_ch.left_hold, report_ch.right_hold});
            if (stall_seen != stall_asks)
            begin
                stall_seen = stall_asks;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_count == 0)
                begin
                    rx_mode    = $urandom_range(0, 3);
                    rx_count   = $urandom_range(16, 96);
                    rx_pattern = $urandom;
                end
                rx_count--;
                case (rx_mode)
                    0: report_ch.ready <= 1'b1;
                    1: report_ch.ready <= 1'($urandom_range(0, 1));
                    2: report_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        report_ch.ready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
                    end
                endcase
            end
        end
    end

    task automatic send_tick(input logic [3:0] pins);
        if (burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                     : $urandom_range(1, 8);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.left_main_n   <= pins[3];
        sample_ch.left_extra_n  <= pins[2];
        sample_ch.right_main_n  <= pins[1];
        sample_ch.right_extra_n <= pins[0];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_tick(pins_t'(pins));
        ticks_sent++;
        burst_left--;
    endtask

    task automatic hold_pins(input logic [3:0] pins, input int n);
        repeat (n) send_tick(pins);
    endtask

    // drop valid, wait for every report, then let the pipeline empty
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (REPORT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_intervals(input logic [THRESH_W-1:0] deb,
                                 input logic [THRESH_W-1:0] hold);
        wr_en    <= 1'b1;
        wr_index <= REG_DEBOUNCE;
        wr_data  <= deb;
        @(posedge clk);
        wr_index <= REG_HOLD;
        wr_data  <= hold;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        sb.configure(deb, hold);
        cur_deb  = deb;
        cur_hold = hold;
    endtask

    function automatic logic [3:0] any_press();
        logic [3:0] v;
        v = 4'($urandom_range(0, 14));
        return v;
    endfunction

    task automatic press_gesture();
        logic [3:0] pins;
        int         len;
        int         swap_at;
        pins    = any_press();
        len     = $urandom_range(1, int'(cur_deb) + int'(cur_hold) + 4);
        swap_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        repeat ($urandom_range(0, 2)) send_tick(RELEASED);
        for (int i = 0; i < len; i++)
        begin
            if (i == swap_at)
                pins = 4'($urandom_range(0, 15));
            send_tick(pins);
        end
        repeat ($urandom_range(1, 3)) send_tick(RELEASED);
    endtask

    initial
    begin
        #(4_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [3:0] seq [$];
        int         start;
        rst_n                   <= 1'b0;
        wr_en                   <= 1'b0;
        wr_index                <= REG_DEBOUNCE;
        wr_data                 <= '0;
        sample_ch.valid         <= 1'b0;
        sample_ch.left_main_n   <= 1'b1;
        sample_ch.left_extra_n  <= 1'b1;
        sample_ch.right_main_n  <= 1'b1;
        sample_ch.right_extra_n <= 1'b1;
        ticks_sent = 0;
        burst_left = 0;
        stall_asks = 0;
        cur_deb    = DEBOUNCE_RESET;
        cur_hold   = HOLD_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset intervals: one short press
        hold_pins(4'b1110, 105);
        hold_pins(RELEASED, 2);
        settle();

        // zero intervals: immediate holds, disabled sides, early release
        set_intervals('0, '0);
        seq = {4'b1111, 4'b0111, 4'b0111, 4'b0111, 4'b1110, 4'b1111,
               4'b0000, 4'b1111, 4'b1011, 4'b1010, 4'b1111};
        foreach (seq[i])
            send_tick(seq[i]);
        settle();

        // short intervals: single and double presses, mixed press and hold
        set_intervals(16'd1, 16'd2);
        seq = {4'b1101, 4'b1101, 4'b1111,
               4'b0110, 4'b0110, 4'b1110, 4'b1111,
               4'b0110, 4'b0110, 4'b1110, 4'b1110,
               4'b0100, 4'b0100, 4'b0100, 4'b0100, 4'b1111};
        foreach (seq[i])
            send_tick(seq[i]);
        settle();

        for (int k = 0; k < 8; k++)
        begin
            if (k == 0)
                set_intervals('0, '0);
            else
                set_intervals(THRESH_W'($urandom_range(0, 4)),
                              THRESH_W'($urandom_range(0, 8)));
            if (k == 0)
                stall_asks <= stall_asks + 1;
            start = ticks_sent;
            while (ticks_sent - start < 64)
            begin
                if (k == 3 && ticks_sent - start >= 32 && ticks_sent - start < 37)
                    settle();
                if ($urandom_range(0, 9) < 8)
                    press_gesture();
                else
                    repeat ($urandom_range(1, 5)) send_tick(4'($urandom_range(0, 15)));
            end
            hold_pins(RELEASED, 2);
            settle();
        end

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
